FILE: rtl/core/positional_ordered_list_engine_defines.svh
// assertion macros for the list engine
`ifndef POSITIONAL_ORDERED_LIST_ENGINE_DEFINES_SVH
`define POSITIONAL_ORDERED_LIST_ENGINE_DEFINES_SVH
`ifndef SYNTHESIS
`define POLE_CHECK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define POLE_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);
`else
`define POLE_CHECK(label, prop, msg)
`define POLE_NEXT(label, ante, cons, msg)
`endif
`endif

FILE: rtl/core/pole_pkg.sv
`timescale 1ns / 1ps
package pole_pkg;

  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 32;

  localparam int OP_W     = 3;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 5;
  localparam int STATUS_W = 2;
  localparam int ELEM_W   = 32;
  localparam int COUNT_W  = 5;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  typedef logic signed [DATA_WIDTH-1:0] data_t;

  typedef enum logic [OP_W-1:0] {
    OP_INS_FIRST = 3'd0,
    OP_INS_LAST  = 3'd1,
    OP_INS_AT    = 3'd2,
    OP_DEL_FIRST = 3'd3,
    OP_DEL_LAST  = 3'd4,
    OP_DEL_AT    = 3'd5,
    OP_DISPLAY   = 3'd6
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_WALK
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic walk_start;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic walk;
    logic walk_last;
  } sts_t;

endpackage

FILE: rtl/core/pole_channels.sv
`timescale 1ns / 1ps
interface pole_in_if;
  import pole_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [OP_W-1:0]           op;
  logic signed [VALUE_W-1:0] value;
  logic [POS_W-1:0]          position;

  modport source (output valid, output op, output value, output position, input ready);
  modport sink   (input valid, input op, input value, input position, output ready);
endinterface

interface pole_out_if;
  import pole_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic signed [ELEM_W-1:0] element;
  logic [COUNT_W-1:0]       count;
  logic                     last;

  modport source (output valid, output status, output element, output count, output last,
                  input ready);
  modport sink   (input valid, input status, input element, input count, input last,
                  output ready);
endinterface

FILE: rtl/core/pole_ctrl.sv
`timescale 1ns / 1ps
module pole_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  pole_pkg::sts_t sts,
  output pole_pkg::cmd_t cmd,
  output logic           in_ready
);
  import pole_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (sts.walk) state_nxt = S_WALK;
        else if (sts.out_free) state_nxt = S_IDLE;
      end
      S_WALK: begin
        if (sts.out_free && sts.walk_last) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_EXEC: begin
        cmd.walk_start = sts.walk;
        cmd.exec       = !sts.walk && sts.out_free;
      end
      S_WALK: begin
        cmd.emit = sts.out_free;
      end
      default: ;
    endcase
  end

endmodule

FILE: rtl/core/pole_dp.sv
`timescale 1ns / 1ps
`include "positional_ordered_list_engine_defines.svh"
module pole_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  pole_pkg::cmd_t                      cmd,
  output pole_pkg::sts_t                      sts,
  input  logic [pole_pkg::OP_W-1:0]           in_op,
  input  logic signed [pole_pkg::VALUE_W-1:0] in_value,
  input  logic [pole_pkg::POS_W-1:0]          in_position,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic [pole_pkg::STATUS_W-1:0]       out_status,
  output logic signed [pole_pkg::ELEM_W-1:0]  out_element,
  output logic [pole_pkg::COUNT_W-1:0]        out_count,
  output logic                                out_last
);
  import pole_pkg::*;

  // latched request
  logic [OP_W-1:0]  op_r;
  data_t            value_r;
  logic [POS_W-1:0] pos_r;

  data_t            cells_r   [CAPACITY];
  data_t            cells_nxt [CAPACITY];
  data_t            up        [CAPACITY];
  data_t            down      [CAPACITY];
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic [IDX_W-1:0] idx_r;
  data_t            rd;

  logic                     out_valid_r;
  status_t                  status_r;
  logic signed [ELEM_W-1:0] element_r;
  logic [COUNT_W-1:0]       count_out_r;
  logic                     last_r;

  logic [CMP_W-1:0] cnt_c;
  logic [CMP_W-1:0] pos_c;
  logic [CMP_W-1:0] idx_c;
  logic             full;
  logic             empty;
  logic             do_ins;
  logic             do_del;
  status_t          st;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_op;
      value_r <= DATA_WIDTH'(in_value);
      pos_r   <= in_position;
    end
  end

  // neighbor taps for parallel shifting
  for (genvar g = 0; g < CAPACITY; g++) begin : g_tap
    if (g == 0) begin : g_first
      assign up[g] = value_r;
    end else begin : g_rest
      assign up[g] = cells_r[g-1];
    end
    if (g == CAPACITY - 1) begin : g_top
      assign down[g] = cells_r[g];
    end else begin : g_below
      assign down[g] = cells_r[g+1];
    end
  end

  always_comb begin
    cnt_c  = CMP_W'(count_r);
    pos_c  = CMP_W'(pos_r);
    full   = (count_r == CNT_W'(CAPACITY));
    empty  = (count_r == '0);
    st     = ST_OK;
    do_ins = 1'b0;
    do_del = 1'b0;
    idx_c  = '0;
    unique case (op_r)
      OP_INS_FIRST: begin
        if (full) st = ST_FULL;
        else do_ins = 1'b1;
      end
      OP_INS_LAST: begin
        idx_c = cnt_c;
        if (full) st = ST_FULL;
        else do_ins = 1'b1;
      end
      OP_INS_AT: begin
        idx_c = pos_c - CMP_W'(1);
        if (pos_c == '0 || pos_c > cnt_c + CMP_W'(1)) st = ST_BADPOS;
        else if (full) st = ST_FULL;
        else do_ins = 1'b1;
      end
      OP_DEL_FIRST: begin
        if (empty) st = ST_EMPTY;
        else do_del = 1'b1;
      end
      OP_DEL_LAST: begin
        idx_c = cnt_c - CMP_W'(1);
        if (empty) st = ST_EMPTY;
        else do_del = 1'b1;
      end
      OP_DEL_AT: begin
        idx_c = pos_c - CMP_W'(1);
        if (pos_c == '0 || pos_c > cnt_c) st = ST_BADPOS;
        else do_del = 1'b1;
      end
      OP_DISPLAY: begin
        if (empty) st = ST_EMPTY;
      end
      default: ;
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.exec && do_ins) count_nxt = count_r + CNT_W'(1);
    else if (cmd.exec && do_del) count_nxt = count_r - CNT_W'(1);
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cells_nxt[i] = cells_r[i];
      if (do_ins) begin
        if (CMP_W'(i) > idx_c) cells_nxt[i] = up[i];
        else if (CMP_W'(i) == idx_c) cells_nxt[i] = value_r;
      end else if (do_del && CMP_W'(i) >= idx_c) begin
        cells_nxt[i] = down[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      cells_r <= cells_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.exec) begin
      count_r <= count_nxt;
    end
  end

  // display walk
  always_ff @(posedge clk) begin
    if (cmd.walk_start) begin
      idx_r <= '0;
    end else if (cmd.emit) begin
      idx_r <= idx_r + IDX_W'(1);
    end
  end

  assign rd = cells_r[idx_r];

  assign sts.out_free  = !out_valid_r || out_ready;
  assign sts.walk      = (op_r == OP_DISPLAY) && !empty;
  assign sts.walk_last = ((CNT_W'(idx_r) + CNT_W'(1)) == count_r);

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.exec || cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status_r    <= st;
      element_r   <= '0;
      count_out_r <= COUNT_W'(count_nxt);
      last_r      <= 1'b1;
    end else if (cmd.emit) begin
      status_r    <= ST_OK;
      element_r   <= ELEM_W'(rd);
      count_out_r <= COUNT_W'(count_r);
      last_r      <= sts.walk_last;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_status  = status_r;
  assign out_element = element_r;
  assign out_count   = count_out_r;
  assign out_last    = last_r;

  `POLE_CHECK(a_count_bound, count_r <= CNT_W'(CAPACITY), "entry count above capacity")
  `POLE_CHECK(a_result_free, (cmd.exec || cmd.emit) |-> (!out_valid_r || out_ready), "result register overwritten")
  `POLE_CHECK(a_walk_range, cmd.emit |-> (CNT_W'(idx_r) < count_r), "walk index past last entry")
  `POLE_NEXT(a_insert_count, cmd.exec && do_ins, count_r == $past(count_r) + CNT_W'(1), "insert did not grow list")

endmodule

FILE: rtl/core/positional_ordered_list_engine.sv
// channel  dir  handshake      payload
// in_ch    in   valid/ready    op, value, position
// out_ch   out  valid/ready    status, element, count, last
//
// a request is taken into the request register while idle and executed once the
// single result register is free; an insert, delete or empty display gives one
// result, and no new request is taken until the last one is done
// a display of n entries emits one per cycle from the cell array unless out_ch stalls
// reset (rst_n low, synchronous) empties the list and drops any pending result
// a stalled out_ch holds the controller until the result register frees up
`timescale 1ns / 1ps
module positional_ordered_list_engine (
  input logic        clk,
  input logic        rst_n,
  pole_in_if.sink    in_ch,
  pole_out_if.source out_ch
);
  import pole_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  pole_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .sts      (sts),
    .cmd      (cmd),
    .in_ready (in_ready)
  );

  pole_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_op       (in_ch.op),
    .in_value    (in_ch.value),
    .in_position (in_ch.position),
    .out_ready   (out_ch.ready),
    .out_valid   (out_ch.valid),
    .out_status  (out_ch.status),
    .out_element (out_ch.element),
    .out_count   (out_ch.count),
    .out_last    (out_ch.last)
  );

  assign in_ch.ready = in_ready;

endmodule
